// ----- sv/uv_sphere_vertex_generator_core_defines.svh -----
// Assertion macros for the UV sphere vertex generator.
// Used by the top level; expects clk and rst in scope.
`ifndef UV_SPHERE_VERTEX_GENERATOR_CORE_DEFINES_SVH
`define UV_SPHERE_VERTEX_GENERATOR_CORE_DEFINES_SVH

// Check a condition at every edge outside reset
`define UVSG_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle
`define UVSG_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- sv/uvsg_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the UV sphere vertex generator.
// No dependencies.
package uvsg_pkg;

  localparam int IDX_W  = 9;
  localparam int CNT_W  = 9;
  localparam int RAD_W  = 16;
  localparam int POS_W  = 17;
  localparam int NRM_W  = 16;
  localparam int TEX_W  = 17;
  localparam int BASE_W = 17;

  // Register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_RADIUS  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_STACKS  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SECTORS = 2'd2;

  localparam logic [RAD_W-1:0] RADIUS_RST  = 16'd256;
  localparam logic [CNT_W-1:0] STACKS_RST  = 9'd16;
  localparam logic [CNT_W-1:0] SECTORS_RST = 9'd32;

  // Divider: quotient bits and dividend width
  localparam int DIV_QW = 33;
  localparam int DIV_NW = IDX_W + DIV_QW;

  // Angles and CORDIC
  localparam int PH_W = 32;
  localparam int Q_W  = 32;
  localparam int CR_W = 34;
  localparam logic signed [CR_W-1:0] CORDIC_GAIN_INIT = 34'sd652032874;
  localparam logic [PH_W-1:0] QUARTER = 32'h4000_0000;
  localparam int ATAN_N = 24;
  localparam logic [31:0] ATAN_TURNS [ATAN_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Quarter-turn codes
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [IDX_W-1:0]  stack_idx;
    logic [IDX_W-1:0]  sector_idx;
    logic [CNT_W-1:0]  stacks;
    logic [CNT_W-1:0]  sectors;
    logic [BASE_W-1:0] base_index;
    logic              upper_tri_valid;
    logic              lower_tri_valid;
  } point_item_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
  } queue_stat_t;

endpackage

// ----- sv/uvsg_if.sv -----
`timescale 1ns / 1ps
// Channel interfaces: grid point requests, vertex results, register writes.
// Depends on uvsg_pkg.
interface uvsg_in_if import uvsg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] stack_idx;
  logic [IDX_W-1:0] sector_idx;
  modport source (output valid, stack_idx, sector_idx, input ready);
  modport sink (input valid, stack_idx, sector_idx, output ready);
endinterface

interface uvsg_out_if import uvsg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic signed [NRM_W-1:0]  norm_x;
  logic signed [NRM_W-1:0]  norm_y;
  logic signed [NRM_W-1:0]  norm_z;
  logic [TEX_W-1:0]         tex_u;
  logic [TEX_W-1:0]         tex_v;
  logic [BASE_W-1:0]        base_index;
  logic                     upper_tri_valid;
  logic                     lower_tri_valid;
  modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u,
                  tex_v, base_index, upper_tri_valid, lower_tri_valid, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u,
                tex_v, base_index, upper_tri_valid, lower_tri_valid, output ready);
endinterface

interface uvsg_cfg_if import uvsg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] index;
  logic [31:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/uvsg_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts grid points, clamps counts and indexes, computes the
// vertex index and triangle flags, and queues the request. Uses uvsg_pkg.
module uvsg_front import uvsg_pkg::*; #(
  parameter int MAX_STACKS  = 256,
  parameter int MAX_SECTORS = 256
) (
  input  logic             clk,
  input  logic             rst,
  uvsg_in_if.sink          point,
  input  logic [CNT_W-1:0] stack_count,
  input  logic [CNT_W-1:0] sector_count,
  output point_item_t      q_item,
  output logic             q_vld,
  input  logic             q_pop,
  output queue_stat_t      q_stat
);

  localparam logic [CNT_W+1:0] MAX_ST = (CNT_W+2)'(MAX_STACKS);
  localparam logic [CNT_W+1:0] MAX_SE = (CNT_W+2)'(MAX_SECTORS);

  logic [CNT_W-1:0]     stacks, sectors, stacks_m1;
  logic [IDX_W-1:0]     i_sat, j_sat;
  logic [CNT_W:0]       sec_p1;
  logic [IDX_W+CNT_W:0] prod;
  logic                 in_mesh;
  point_item_t          entry;
  point_item_t          mem [QDEPTH];
  logic [QPTR_W-1:0]    wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]    count;
  logic                 push;

  // Clamp counts and saturate indexes
  always_comb begin
    if (stack_count == '0) begin
      stacks = CNT_W'(1);
    end else if ({2'b00, stack_count} > MAX_ST) begin
      stacks = MAX_ST[CNT_W-1:0];
    end else begin
      stacks = stack_count;
    end
    if (sector_count == '0) begin
      sectors = CNT_W'(1);
    end else if ({2'b00, sector_count} > MAX_SE) begin
      sectors = MAX_SE[CNT_W-1:0];
    end else begin
      sectors = sector_count;
    end
    i_sat = (point.stack_idx > stacks) ? stacks : point.stack_idx;
    j_sat = (point.sector_idx > sectors) ? sectors : point.sector_idx;
  end

  // Classify: vertex index and triangle flags
  always_comb begin
    stacks_m1 = stacks - CNT_W'(1);
    sec_p1    = {1'b0, sectors} + (CNT_W+1)'(1);
    prod      = (IDX_W+CNT_W+1)'(i_sat) * (IDX_W+CNT_W+1)'(sec_p1)
              + (IDX_W+CNT_W+1)'(j_sat);
    in_mesh   = (i_sat < stacks) && (j_sat < sectors);
    entry.stack_idx       = i_sat;
    entry.sector_idx      = j_sat;
    entry.stacks          = stacks;
    entry.sectors         = sectors;
    entry.base_index      = prod[BASE_W-1:0];
    entry.upper_tri_valid = in_mesh && (i_sat != '0);
    entry.lower_tri_valid = in_mesh && (i_sat != stacks_m1);
  end

  assign point.ready = (count != QCNT_W'(QDEPTH));
  assign push        = point.valid && point.ready;

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry;
    end
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(q_pop);
    end
  end

  assign q_item       = mem[rd_ptr];
  assign q_vld        = (count != '0);
  assign q_stat.count = count;

endmodule

// ----- sv/uvsg_div.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, small divisor.
// Uses uvsg_pkg; the dividend's top bits must stay below the divisor.
module uvsg_div import uvsg_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [DIV_NW-1:0] num,
  input  logic [CNT_W-1:0]  den,
  output logic [DIV_QW-1:0] quo
);

  logic [CNT_W-1:0]  rem_q  [DIV_QW];
  logic [DIV_QW-1:0] work_q [DIV_QW];
  logic [CNT_W-1:0]  den_q  [DIV_QW];

  for (genvar s = 0; s < DIV_QW; s++) begin : g_stage
    logic [CNT_W-1:0]  rem_i;
    logic [DIV_QW-1:0] work_i;
    logic [CNT_W-1:0]  den_i;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;

    if (s == 0) begin : g_first
      assign rem_i  = num[DIV_NW-1:DIV_QW];
      assign work_i = num[DIV_QW-1:0];
      assign den_i  = den;
    end else begin : g_next
      assign rem_i  = rem_q[s-1];
      assign work_i = work_q[s-1];
      assign den_i  = den_q[s-1];
    end

    // Shift in one dividend bit and try a subtract
    always_comb begin
      trial = {rem_i, work_i[DIV_QW-1]};
      diff  = trial - {1'b0, den_i};
      ge    = (trial >= {1'b0, den_i});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s]  <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        work_q[s] <= {work_i[DIV_QW-2:0], ge};
        den_q[s]  <= den_i;
      end
    end
  end

  assign quo = work_q[DIV_QW-1];

endmodule

// ----- sv/uvsg_cordic.sv -----
`timescale 1ns / 1ps
// Pipelined rotation CORDIC: cosine and sine of a phase in turns, Q2.30.
// One stage per rotation step plus a quarter-turn stage. Uses uvsg_pkg.
module uvsg_cordic import uvsg_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [PH_W-1:0]       phase,
  output logic signed [Q_W-1:0] cosv,
  output logic signed [Q_W-1:0] sinv
);

  logic signed [CR_W-1:0] xr [STEPS];
  logic signed [CR_W-1:0] yr [STEPS];
  logic signed [PH_W-1:0] zr [STEPS];
  logic [1:0]             qr [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic signed [CR_W-1:0] xi, yi, dx, dy;
    logic signed [PH_W-1:0] zi, at;
    logic [1:0]             qi;

    if (k == 0) begin : g_first
      assign xi = CORDIC_GAIN_INIT;
      assign yi = '0;
      assign zi = $signed({2'b00, phase[PH_W-3:0]});
      assign qi = phase[PH_W-1:PH_W-2];
    end else begin : g_next
      assign xi = xr[k-1];
      assign yi = yr[k-1];
      assign zi = zr[k-1];
      assign qi = qr[k-1];
    end

    assign dx = yi >>> k;
    assign dy = xi >>> k;
    assign at = $signed(ATAN_TURNS[k]);

    // Rotate toward zero residual angle
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[PH_W-1]) begin
          xr[k] <= xi - dx;
          yr[k] <= yi + dy;
          zr[k] <= zi - at;
        end else begin
          xr[k] <= xi + dx;
          yr[k] <= yi - dy;
          zr[k] <= zi + at;
        end
        qr[k] <= qi;
      end
    end
  end

  logic signed [CR_W-1:0] xf, yf, xn, yn;
  assign xf = xr[STEPS-1];
  assign yf = yr[STEPS-1];
  assign xn = -xf;
  assign yn = -yf;

  // Apply the quarter turn exactly
  always_ff @(posedge clk) begin
    if (en) begin
      case (qr[STEPS-1])
        QUAD_0: begin
          cosv <= xf[Q_W-1:0];
          sinv <= yf[Q_W-1:0];
        end
        QUAD_1: begin
          cosv <= yn[Q_W-1:0];
          sinv <= xf[Q_W-1:0];
        end
        QUAD_2: begin
          cosv <= xn[Q_W-1:0];
          sinv <= yn[Q_W-1:0];
        end
        default: begin
          cosv <= yf[Q_W-1:0];
          sinv <= xn[Q_W-1:0];
        end
      endcase
    end
  end

endmodule

// ----- sv/uvsg_back.sv -----
`timescale 1ns / 1ps
// Back end: divides for phases and texture coordinates, runs two CORDICs,
// forms normal and position, and holds the result register. Uses uvsg_pkg.
module uvsg_back import uvsg_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  point_item_t      item,
  input  logic             item_vld,
  output logic             q_pop,
  input  logic [RAD_W-1:0] radius,
  uvsg_out_if.source       vertex
);

  localparam int DB = STEPS + 2;

  logic              en;
  logic              out_vld;
  logic [DIV_NW-1:0] num_lat, num_lon, num_tu, num_tv;
  logic [DIV_QW-1:0] q_lat, q_lon, q_tu, q_tv;
  logic [PH_W-1:0]   lat_ph, lon_ph;
  logic signed [Q_W-1:0] cl, sl, co, so;
  logic signed [Q_W-1:0] ux, uy, uz;

  logic              va     [DIV_QW];
  logic [BASE_W-1:0] base_a [DIV_QW];
  logic              up_a   [DIV_QW];
  logic              lo_a   [DIV_QW];

  logic              vb     [DB];
  logic [BASE_W-1:0] base_b [DB];
  logic              up_b   [DB];
  logic              lo_b   [DB];
  logic [TEX_W-1:0]  tu_b   [DB];
  logic [TEX_W-1:0]  tv_b   [DB];

  // Round a Q4.60 product back to Q2.30
  function automatic logic signed [Q_W-1:0] rnd30(input logic signed [2*Q_W-1:0] p);
    logic signed [2*Q_W-1:0] t;
    t = (p + (2*Q_W)'(64'sd536870912)) >>> 30;
    return t[Q_W-1:0];
  endfunction

  // Unit component to Q1.14 normal
  function automatic logic [NRM_W-1:0] to_norm(input logic signed [Q_W-1:0] u);
    logic signed [Q_W-1:0] t;
    t = (u + 32'sd32768) >>> 16;
    if (t > 32'sd16384) begin
      t = 32'sd16384;
    end else if (t < -32'sd16384) begin
      t = -32'sd16384;
    end
    return t[NRM_W-1:0];
  endfunction

  // Radius times unit component to Q8.8 position
  function automatic logic [POS_W-1:0] to_pos(input logic [RAD_W-1:0] r,
                                              input logic signed [Q_W-1:0] u);
    logic signed [RAD_W+Q_W:0] p;
    logic signed [RAD_W+Q_W:0] t;
    p = $signed({1'b0, r}) * u;
    t = (p + (RAD_W+Q_W+1)'(64'sd536870912)) >>> 30;
    if (t > (RAD_W+Q_W+1)'(64'sd65535)) begin
      t = (RAD_W+Q_W+1)'(64'sd65535);
    end else if (t < -(RAD_W+Q_W+1)'(64'sd65535)) begin
      t = -(RAD_W+Q_W+1)'(64'sd65535);
    end
    return t[POS_W-1:0];
  endfunction

  // Whole back end moves when the result register is free or taken
  assign en    = !out_vld || vertex.ready;
  assign q_pop = en && item_vld;

  // Rounded dividends: index scaled plus half the count
  always_comb begin
    num_lat = {2'b00, item.stack_idx, 31'd0}
            + {{(DIV_NW-CNT_W+1){1'b0}}, item.stacks[CNT_W-1:1]};
    num_lon = {1'b0, item.sector_idx, 32'd0}
            + {{(DIV_NW-CNT_W+1){1'b0}}, item.sectors[CNT_W-1:1]};
    num_tu  = {17'd0, item.sector_idx, 16'd0}
            + {{(DIV_NW-CNT_W+1){1'b0}}, item.sectors[CNT_W-1:1]};
    num_tv  = {17'd0, item.stack_idx, 16'd0}
            + {{(DIV_NW-CNT_W+1){1'b0}}, item.stacks[CNT_W-1:1]};
  end

  uvsg_div u_div_lat (.clk(clk), .en(en), .num(num_lat), .den(item.stacks), .quo(q_lat));
  uvsg_div u_div_lon (.clk(clk), .en(en), .num(num_lon), .den(item.sectors), .quo(q_lon));
  uvsg_div u_div_tu (.clk(clk), .en(en), .num(num_tu), .den(item.sectors), .quo(q_tu));
  uvsg_div u_div_tv (.clk(clk), .en(en), .num(num_tv), .den(item.stacks), .quo(q_tv));

  // Latitude runs from a quarter turn downward
  assign lat_ph = QUARTER - q_lat[PH_W-1:0];
  assign lon_ph = q_lon[PH_W-1:0];

  uvsg_cordic #(.STEPS(STEPS)) u_cordic_lat (
    .clk(clk), .en(en), .phase(lat_ph), .cosv(cl), .sinv(sl)
  );
  uvsg_cordic #(.STEPS(STEPS)) u_cordic_lon (
    .clk(clk), .en(en), .phase(lon_ph), .cosv(co), .sinv(so)
  );

  // Carry valid beside the dividers and CORDICs
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DIV_QW; s++) va[s] <= 1'b0;
      for (int s = 0; s < DB; s++) vb[s] <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      va[0] <= q_pop;
      for (int s = 1; s < DIV_QW; s++) va[s] <= va[s-1];
      vb[0] <= va[DIV_QW-1];
      for (int s = 1; s < DB; s++) vb[s] <= vb[s-1];
      out_vld <= vb[DB-1];
    end
  end

  // Carry index, flags and texture coordinates through divider and CORDIC latency
  always_ff @(posedge clk) begin
    if (en) begin
      base_a[0] <= item.base_index;
      up_a[0]   <= item.upper_tri_valid;
      lo_a[0]   <= item.lower_tri_valid;
      for (int s = 1; s < DIV_QW; s++) begin
        base_a[s] <= base_a[s-1];
        up_a[s]   <= up_a[s-1];
        lo_a[s]   <= lo_a[s-1];
      end
      base_b[0] <= base_a[DIV_QW-1];
      up_b[0]   <= up_a[DIV_QW-1];
      lo_b[0]   <= lo_a[DIV_QW-1];
      tu_b[0]   <= q_tu[TEX_W-1:0];
      tv_b[0]   <= q_tv[TEX_W-1:0];
      for (int s = 1; s < DB; s++) begin
        base_b[s] <= base_b[s-1];
        up_b[s]   <= up_b[s-1];
        lo_b[s]   <= lo_b[s-1];
        tu_b[s]   <= tu_b[s-1];
        tv_b[s]   <= tv_b[s-1];
      end
    end
  end

  // Unit direction
  always_ff @(posedge clk) begin
    if (en) begin
      ux <= rnd30(cl * co);
      uy <= rnd30(cl * so);
      uz <= sl;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (en) begin
      vertex.pos_x           <= to_pos(radius, ux);
      vertex.pos_y           <= to_pos(radius, uy);
      vertex.pos_z           <= to_pos(radius, uz);
      vertex.norm_x          <= to_norm(ux);
      vertex.norm_y          <= to_norm(uy);
      vertex.norm_z          <= to_norm(uz);
      vertex.tex_u           <= tu_b[DB-1];
      vertex.tex_v           <= tv_b[DB-1];
      vertex.base_index      <= base_b[DB-1];
      vertex.upper_tri_valid <= up_b[DB-1];
      vertex.lower_tri_valid <= lo_b[DB-1];
    end
  end

  assign vertex.valid = out_vld;

endmodule

// ----- sv/uv_sphere_vertex_generator_core.sv -----
`timescale 1ns / 1ps
// Channel  | Dir | Carries
// cfg      | in  | register index, write data (radius, stack count, sector count)
// point    | in  | stack_idx, sector_idx
// vertex   | out | position, normal, texture coords, vertex index, triangle flags
//
// One point per cycle sustained while vertex.ready holds. The pipeline is a
// 33-stage bit-per-stage divider, one CORDIC stage per step plus a quarter-turn
// stage, one multiply stage and the result register.
// Synchronous reset restores the register defaults and empties all stages.
// A stalled result freezes the back pipeline; a four-entry request queue
// absorbs points until it fills and point.ready drops.
// Depends on uvsg_pkg, uvsg_if, uvsg_front, uvsg_back and the defines header.
`include "uv_sphere_vertex_generator_core_defines.svh"
module uv_sphere_vertex_generator_core import uvsg_pkg::*; #(
  parameter int MAX_STACKS   = 256,
  parameter int MAX_SECTORS  = 256,
  parameter int CORDIC_STEPS = 16
) (
  input  logic       clk,
  input  logic       rst,
  uvsg_cfg_if.sink   cfg,
  uvsg_in_if.sink    point,
  uvsg_out_if.source vertex
);

  localparam int NSTEP = (CORDIC_STEPS > ATAN_N) ? ATAN_N : CORDIC_STEPS;

  logic [RAD_W-1:0] radius;
  logic [CNT_W-1:0] stack_count;
  logic [CNT_W-1:0] sector_count;
  point_item_t      q_item;
  logic             q_vld;
  logic             q_pop;
  queue_stat_t      q_stat;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= RADIUS_RST;
      stack_count  <= STACKS_RST;
      sector_count <= SECTORS_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_RADIUS:  radius       <= cfg.data[RAD_W-1:0];
        REG_STACKS:  stack_count  <= cfg.data[CNT_W-1:0];
        REG_SECTORS: sector_count <= cfg.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  uvsg_front #(
    .MAX_STACKS(MAX_STACKS),
    .MAX_SECTORS(MAX_SECTORS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .point(point),
    .stack_count(stack_count),
    .sector_count(sector_count),
    .q_item(q_item),
    .q_vld(q_vld),
    .q_pop(q_pop),
    .q_stat(q_stat)
  );

  uvsg_back #(
    .STEPS(NSTEP)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .item(q_item),
    .item_vld(q_vld),
    .q_pop(q_pop),
    .radius(radius),
    .vertex(vertex)
  );

  `UVSG_ASSERT_ALWAYS(a_queue_bound, q_stat.count <= QCNT_W'(QDEPTH), "request queue overflow")
  `UVSG_ASSERT_ALWAYS(a_ready_match, point.ready == (q_stat.count != QCNT_W'(QDEPTH)), "ready mismatch")
  `UVSG_ASSERT_IMPLIES(a_no_pop_stall, vertex.valid && !vertex.ready, !q_pop, "pop while stalled")
  `UVSG_ASSERT_IMPLIES(a_pop_nonempty, q_pop, q_stat.count != '0, "pop from empty queue")

endmodule
